// ----- rtl/bal_pkg.sv -----
package bal_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;
	localparam int OP_W     = 3;
	localparam int IDX_W    = 5;
	localparam int CNT_W    = 5;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_SET    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [WORD_W-1:0] word_t;

	// broadcast from the controller to every cell; the command strobes are already gated by accept and ok
	typedef struct packed {
		logic  load;
		logic  shift_up;
		logic  shift_down;
		logic  clear;
		logic  rd;
		cnt_t  pos;
		word_t value;
		logic  last_en;
		cnt_t  last_pos;
	} cell_cmd_t;

endpackage

// ----- rtl/bal_in_if.sv -----
interface bal_in_if;
	import bal_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [IDX_W-1:0]     index;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output op, output index, output value, input ready);
	modport sink (input valid, input op, input index, input value, output ready);

endinterface

// ----- rtl/bal_out_if.sv -----
interface bal_out_if;
	import bal_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [WORD_W-1:0] read_value;
	logic [CNT_W-1:0]         count;
	logic                     is_empty;
	logic                     is_full;
	logic signed [WORD_W-1:0] first_value;
	logic signed [WORD_W-1:0] last_value;

	modport source (output valid, output ok, output read_value, output count,
		output is_empty, output is_full, output first_value, output last_value,
		input ready);
	modport sink (input valid, input ok, input read_value, input count,
		input is_empty, input is_full, input first_value, input last_value,
		output ready);

endinterface

// ----- rtl/bal_ctrl.sv -----
module bal_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic [bal_pkg::OP_W-1:0] op,
	input  logic [bal_pkg::IDX_W-1:0] index,
	input  bal_pkg::word_t           value,
	output bal_pkg::cell_cmd_t       cmd,
	output logic                     ok,
	output bal_pkg::cnt_t            nxt_used
);
	import bal_pkg::*;

	cnt_t used_q;
	cnt_t idx;
	logic not_full;
	logic in_range;
	logic do_load, do_up, do_down, do_clear, do_rd;
	cnt_t load_pos;
	cnt_t cnt_after;

	assign idx      = cnt_t'(index);
	assign not_full = (used_q != cnt_t'(CAPACITY));
	assign in_range = (idx < used_q);

	always_comb begin
		ok        = 1'b0;
		do_load   = 1'b0;
		do_up     = 1'b0;
		do_down   = 1'b0;
		do_clear  = 1'b0;
		do_rd     = 1'b0;
		load_pos  = idx;
		cnt_after = used_q;
		case (op)
			OP_APPEND: begin
				ok        = not_full;
				do_load   = 1'b1;
				load_pos  = used_q;
				cnt_after = used_q + cnt_t'(1);
			end
			OP_INSERT: begin
				ok        = not_full && (idx <= used_q);
				do_load   = 1'b1;
				do_up     = 1'b1;
				cnt_after = used_q + cnt_t'(1);
			end
			OP_REMOVE: begin
				ok        = in_range;
				do_down   = 1'b1;
				cnt_after = used_q - cnt_t'(1);
			end
			OP_SET: begin
				ok      = in_range;
				do_load = 1'b1;
			end
			OP_READ: begin
				ok    = in_range;
				do_rd = 1'b1;
			end
			OP_CLEAR: begin
				ok        = 1'b1;
				do_clear  = 1'b1;
				cnt_after = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// a refused or idle cycle leaves every cell and the count alone
	assign nxt_used = (fire && ok) ? cnt_after : used_q;

	always_comb begin
		cmd.load       = fire && ok && do_load;
		cmd.shift_up   = fire && ok && do_up;
		cmd.shift_down = fire && ok && do_down;
		cmd.clear      = fire && ok && do_clear;
		cmd.rd         = fire && ok && do_rd;
		cmd.pos        = load_pos;
		cmd.value      = value;
		cmd.last_en    = (nxt_used != '0);
		cmd.last_pos   = nxt_used - cnt_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= nxt_used;
		end
	end

endmodule

// ----- rtl/bal_cell.sv -----
module bal_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  bal_pkg::cnt_t      pos,
	input  bal_pkg::cell_cmd_t cmd,
	input  bal_pkg::word_t     left,
	input  bal_pkg::word_t     right,
	output bal_pkg::word_t     slot,
	output bal_pkg::word_t     rd_tap,
	output bal_pkg::word_t     first_tap,
	output bal_pkg::word_t     last_tap
);
	import bal_pkg::*;

	word_t slot_q;
	word_t slot_d;

	// slots at or above the count always hold zero, so shifting zeros in is safe
	always_comb begin
		if (cmd.clear) begin
			slot_d = '0;
		end else if (cmd.load && (pos == cmd.pos)) begin
			slot_d = cmd.value;
		end else if (cmd.shift_up && (pos > cmd.pos)) begin
			slot_d = left;
		end else if (cmd.shift_down && (pos >= cmd.pos)) begin
			slot_d = right;
		end else begin
			slot_d = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

	assign slot      = slot_q;
	assign rd_tap    = (cmd.rd && (pos == cmd.pos)) ? slot_q : '0;
	assign first_tap = (pos == '0) ? slot_d : '0;
	assign last_tap  = (cmd.last_en && (pos == cmd.last_pos)) ? slot_d : '0;

endmodule

// ----- rtl/bounded_array_list.sv -----
// Result: registered, valid in the cycle after its transaction is accepted.
// Throughput: one operation per cycle unless a result is stalled; every cell compares
// its own position with the index and shifts or loads in the same cycle, so no operation iterates.
// Input is taken while a result waits, as long as that result is taken too.
// Reset: asynchronous, active low; empties the list, zeroes all slots, drops the result.
module bounded_array_list (
	input  logic       clk,
	input  logic       arst_n,
	bal_in_if.sink     req,
	bal_out_if.source  rsp
);
	import bal_pkg::*;

	logic      fire;
	cell_cmd_t cmd;
	logic      ok;
	cnt_t      nxt_used;

	word_t slot_w  [CAPACITY];
	word_t left_w  [CAPACITY];
	word_t right_w [CAPACITY];
	word_t rd_w    [CAPACITY];
	word_t first_w [CAPACITY];
	word_t last_w  [CAPACITY];

	word_t rd_or, first_or, last_or;

	logic  valid_q;
	logic  ok_q;
	word_t read_value_q;
	cnt_t  count_q;
	word_t first_q;
	word_t last_q;

	assign req.ready = !valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	bal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op       (req.op),
		.index    (req.index),
		.value    (req.value),
		.cmd      (cmd),
		.ok       (ok),
		.nxt_used (nxt_used)
	);

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign left_w[k] = '0;
		end else begin : g_body
			assign left_w[k] = slot_w[k-1];
		end
		if (k == CAPACITY - 1) begin : g_tail
			assign right_w[k] = '0;
		end else begin : g_next
			assign right_w[k] = slot_w[k+1];
		end

		bal_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.pos       (cnt_t'(k)),
			.cmd       (cmd),
			.left      (left_w[k]),
			.right     (right_w[k]),
			.slot      (slot_w[k]),
			.rd_tap    (rd_w[k]),
			.first_tap (first_w[k]),
			.last_tap  (last_w[k])
		);
	end

	// each tap is zero except at the one selected cell
	always_comb begin
		rd_or    = '0;
		first_or = '0;
		last_or  = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_or    = rd_or | rd_w[k];
			first_or = first_or | first_w[k];
			last_or  = last_or | last_w[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q         <= ok;
			read_value_q <= rd_or;
			count_q      <= nxt_used;
			first_q      <= first_or;
			last_q       <= last_or;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.count       = count_q;
	assign rsp.is_empty    = (count_q == '0);
	assign rsp.is_full     = (count_q == cnt_t'(CAPACITY));
	assign rsp.first_value = first_q;
	assign rsp.last_value  = last_q;

endmodule

// ----- rtl/bal_checker.sv -----
module bal_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 rsp_ok,
	input bal_pkg::word_t       rsp_read_value,
	input bal_pkg::cnt_t        rsp_count,
	input logic                 rsp_is_empty,
	input logic                 rsp_is_full,
	input bal_pkg::word_t       rsp_first_value,
	input bal_pkg::word_t       rsp_last_value
);
	import bal_pkg::*;

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
		else $error("is_empty disagrees with count");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_full == (rsp_count == cnt_t'(CAPACITY))))
		else $error("is_full disagrees with count");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_is_empty) |-> (rsp_first_value == '0 && rsp_last_value == '0))
		else $error("empty list reports nonzero first or last entry");

	a_refused_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ok) |-> (rsp_read_value == '0))
		else $error("refused operation returns nonzero read_value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count)
			&& $stable(rsp_read_value) && $stable(rsp_ok)))
		else $error("stalled result changed");

endmodule

bind bounded_array_list bal_checker u_bal_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_read_value  (rsp.read_value),
	.rsp_count       (rsp.count),
	.rsp_is_empty    (rsp.is_empty),
	.rsp_is_full     (rsp.is_full),
	.rsp_first_value (rsp.first_value),
	.rsp_last_value  (rsp.last_value)
);

// ----- test/bounded_array_list_chk.sv -----
module bounded_array_list_chk (
	input  logic clk,
	input  logic arst_n,
	bal_in_if    req,
	bal_out_if   rsp,
	output int   fail_count,
	output int   outstanding,
	output int   ops_checked,
	output int   ops_refused,
	output int   full_hits
);
	timeunit 1ns;
	timeprecision 1ps;
	import bal_pkg::*;

	typedef struct packed {
		logic  ok;
		word_t read_value;
		cnt_t  count;
		logic  is_empty;
		logic  is_full;
		word_t first_value;
		word_t last_value;
	} list_result_t;

	bit signed [WORD_W-1:0] list_slots [CAPACITY];
	int                     list_used;
	list_result_t           expected_results [$];
	int                     failures;
	int                     checked;
	int                     refused;
	int                     full_seen;

	// Apply one operation to the shadow list and return the result it should produce.
	function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
			word_t val);
		list_result_t res;
		int pos;
		int k;
		res = '0;
		pos = int'(idx);
		case (op)
			OP_APPEND: begin
				if (list_used < CAPACITY) begin
					list_slots[list_used] = val;
					list_used++;
					res.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				if (list_used < CAPACITY && pos <= list_used) begin
					for (k = list_used; k > pos; k--)
						list_slots[k] = list_slots[k-1];
					list_slots[pos] = val;
					list_used++;
					res.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos < list_used) begin
					for (k = pos; k + 1 < list_used; k++)
						list_slots[k] = list_slots[k+1];
					list_used--;
					list_slots[list_used] = '0;
					res.ok = 1'b1;
				end
			end
			OP_SET: begin
				if (pos < list_used) begin
					list_slots[pos] = val;
					res.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (pos < list_used) begin
					res.read_value = list_slots[pos];
					res.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (k = 0; k < CAPACITY; k++)
					list_slots[k] = '0;
				list_used = 0;
				res.ok = 1'b1;
			end
			default: ;
		endcase
		res.count    = cnt_t'(list_used);
		res.is_empty = (list_used == 0);
		res.is_full  = (list_used == CAPACITY);
		if (list_used != 0) begin
			res.first_value = list_slots[0];
			res.last_value  = list_slots[list_used-1];
		end
		return res;
	endfunction

	function automatic int field_mismatch(string field, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		list_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < CAPACITY; k++)
				list_slots[k] = '0;
			list_used = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			// Results first: a result taken in this cycle belongs to an earlier transaction.
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no operation pending");
					failures++;
				end else begin
					want = expected_results.pop_front();
					failures += field_mismatch("ok", want.ok, rsp.ok);
					failures += field_mismatch("read_value", want.read_value, rsp.read_value);
					failures += field_mismatch("count", want.count, rsp.count);
					failures += field_mismatch("is_empty", want.is_empty, rsp.is_empty);
					failures += field_mismatch("is_full", want.is_full, rsp.is_full);
					failures += field_mismatch("first_value", want.first_value, rsp.first_value);
					failures += field_mismatch("last_value", want.last_value, rsp.last_value);
					checked++;
				end
			end
			if (req.valid && req.ready) begin
				want = apply_list_op(req.op, req.index, req.value);
				if (!want.ok)
					refused++;
				if (want.is_full)
					full_seen++;
				expected_results.push_back(want);
			end
			outstanding <= expected_results.size();
		end
		fail_count  <= failures;
		ops_checked <= checked;
		ops_refused <= refused;
		full_hits   <= full_seen;
	end

	final begin
		if (expected_results.size() != 0)
			$error("%0d expected results never arrived", expected_results.size());
	end

endmodule

// ----- test/bounded_array_list_tb.sv -----
module bounded_array_list_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bal_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7fff_ffff;
	localparam int RANDOM_OPS   = 1300;
	localparam int HOLD_CYCLES  = 60;
	localparam int STALL_LIMIT  = 1000;
	localparam int IDLE_PERCENT = 26;

	typedef enum {MODE_GROW, MODE_MIXED, MODE_SHRINK} traffic_mode_e;

	logic clk;
	logic arst_n;
	bit   steady_run;
	bit   hold_request;
	int   stall_cycles;
	int   chk_failures;
	int   chk_outstanding;
	int   chk_ops;
	int   chk_refused;
	int   chk_full;

	bal_in_if  req ();
	bal_out_if rsp ();

	bounded_array_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bounded_array_list_chk list_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (chk_failures),
		.outstanding (chk_outstanding),
		.ops_checked (chk_ops),
		.ops_refused (chk_refused),
		.full_hits   (chk_full)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side: random back-pressure, one long hold-off on request.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				rsp.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_list_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input word_t val);
		while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op    <= op;
		req.index <= idx;
		req.value <= val;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (chk_outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op(traffic_mode_e mode);
		int r;
		r = $urandom_range(99);
		case (mode)
			MODE_GROW: begin
				if (r < 45) return OP_APPEND;
				if (r < 75) return OP_INSERT;
				if (r < 85) return OP_READ;
				if (r < 93) return OP_SET;
				if (r < 97) return OP_REMOVE;
				if (r < 98) return OP_CLEAR;
			end
			MODE_SHRINK: begin
				if (r < 10) return OP_APPEND;
				if (r < 20) return OP_INSERT;
				if (r < 60) return OP_REMOVE;
				if (r < 75) return OP_READ;
				if (r < 90) return OP_SET;
				if (r < 93) return OP_CLEAR;
			end
			default: begin
				if (r < 20) return OP_APPEND;
				if (r < 40) return OP_INSERT;
				if (r < 60) return OP_REMOVE;
				if (r < 75) return OP_SET;
				if (r < 90) return OP_READ;
				if (r < 94) return OP_CLEAR;
			end
		endcase
		return $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(39))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return '0;
			3:       return -1;
			default: return word_t'($urandom());
		endcase
	endfunction

	initial begin
		traffic_mode_e mode;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.op       = OP_APPEND;
		req.index    = '0;
		req.value    = '0;
		steady_run   = 1'b0;
		hold_request = 1'b0;
		stall_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Refusals on an empty list.
		send_list_op(OP_READ, 5'd0, '0);
		send_list_op(OP_REMOVE, 5'd0, '0);
		send_list_op(OP_SET, 5'd0, 32'sh1111_1111);
		send_list_op(OP_INSERT, 5'd1, 32'sh2222_2222);
		// Build a short list, with an insert at the tail and one in the middle.
		send_list_op(OP_INSERT, 5'd0, WORD_MIN);
		send_list_op(OP_APPEND, 5'd0, WORD_MAX);
		send_list_op(OP_APPEND, 5'd31, -1);
		send_list_op(OP_INSERT, 5'd3, '0);
		send_list_op(OP_INSERT, 5'd1, 32'sh1234_5678);
		send_list_op(OP_READ, 5'd0, '0);
		send_list_op(OP_READ, 5'd4, '0);
		send_list_op(OP_READ, 5'd5, '0);
		send_list_op(OP_READ, 5'd31, '0);
		send_list_op(OP_SET, 5'd2, 32'sh5a5a_a5a5);
		send_list_op(OP_REMOVE, 5'd0, '0);
		send_list_op(OP_REMOVE, 5'd3, '0);
		send_list_op(OP_REMOVE, 5'd1, '0);
		send_list_op(OP_UNDEF_LO, 5'd16, WORD_MAX);
		send_list_op(OP_UNDEF_HI, 5'd31, -1);
		send_list_op(OP_CLEAR, 5'd0, '0);
		send_list_op(OP_READ, 5'd0, '0);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			// Rotate traffic every 50 transactions so the list swings between empty and full.
			case ((n / 50) % 4)
				0, 2:    mode = MODE_GROW;
				1:       mode = MODE_MIXED;
				default: mode = MODE_SHRINK;
			endcase
			if (n == 300)
				hold_request = 1'b1;
			if (n == 600)
				drain_results();
			steady_run = (n >= 700 && n < 900);
			send_list_op(pick_op(mode),
				($urandom_range(99) < 85) ? IDX_W'($urandom_range(16)) : IDX_W'($urandom_range(31)),
				pick_value());
		end

		drain_results();
		repeat (4) @(posedge clk);
		$display("Checked %0d list operations (%0d refused); list reported full %0d times.",
			chk_ops, chk_refused, chk_full);
		$display("Covered all six operations, undefined opcodes, out-of-range indexes and stalls.");
		if (chk_failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
